// ===== rtl/core/lpr_pkg.sv =====
// Package for the LRU page replacement block: field widths, sizing constants
// and the lookup record passed from the front end to the back end.
// No dependencies.
package lpr_pkg;

	localparam int PAGE_W      = 16;
	localparam int SLOT_W      = 4;
	localparam int CFG_W       = 5;
	localparam int FAULT_W     = 32;
	localparam int FRAMES_DEF  = 16;
	localparam int FRAMES_MAX  = 64;
	localparam int IDX_MAX_W   = $clog2(FRAMES_MAX);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = CFG_W'(4);
	localparam logic [FAULT_W-1:0] FAULT_SAT       = '1;

	// Outcome of one lookup, ready for the back end to apply.
	typedef struct packed {
		logic [PAGE_W-1:0]    page;
		logic                 last;
		logic                 hit;
		logic                 was_valid;
		logic [IDX_MAX_W-1:0] slot;
		logic [IDX_MAX_W-1:0] old_rank;
		logic                 evict_valid;
		logic [PAGE_W-1:0]    evict_page;
	} lpr_class_t;

endpackage

// ===== rtl/core/lpr_in_if.sv =====
// Reference channel: valid/ready handshake carrying one page reference.
// Depends on lpr_pkg.
interface lpr_in_if;
	import lpr_pkg::*;

	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page;
	logic              last_reference;

	modport source(output valid, page, last_reference, input ready);
	modport sink(input valid, page, last_reference, output ready);
endinterface

// ===== rtl/core/lpr_out_if.sv =====
// Result channel: valid/ready handshake carrying one lookup result.
// Depends on lpr_pkg.
interface lpr_out_if;
	import lpr_pkg::*;

	logic               valid;
	logic               ready;
	logic               hit;
	logic [SLOT_W-1:0]  slot;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;
	logic [FAULT_W-1:0] fault_count;
	logic               string_done;

	modport source(output valid, hit, slot, evicted_valid, evicted_page, fault_count,
		string_done, input ready);
	modport sink(input valid, hit, slot, evicted_valid, evicted_page, fault_count,
		string_done, output ready);
endinterface

// ===== rtl/core/lpr_front.sv =====
// Front end: takes page references, looks them up against the frame state
// and pushes the lookup outcome. Depends on lpr_pkg and lpr_in_if.
module lpr_front #(
	parameter int  FRAMES = lpr_pkg::FRAMES_DEF,
	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lpr_in_if.sink                    refs,
	input  logic [FRAMES-1:0]         in_use,
	input  logic [lpr_pkg::PAGE_W-1:0] frame_page [FRAMES],
	input  logic [FRAMES-1:0]         frame_valid,
	input  logic [IDX_W-1:0]          age_rank [FRAMES],
	input  logic                      q_empty,
	output logic                      q_push,
	output lpr_pkg::lpr_class_t       push_entry
);
	import lpr_pkg::*;

	logic              vld_s1;
	logic [PAGE_W-1:0] page_s1;
	logic              last_s1;

	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              emp;
	logic [IDX_W-1:0]  emp_idx;
	logic [FRAMES-1:0] vic_oh;
	logic [IDX_W-1:0]  vic_idx;
	logic [IDX_W-1:0]  slot_sel;

	// Look up only once the back end has drained: state is then current.
	assign q_push     = vld_s1 && q_empty;
	assign refs.ready = !vld_s1 || q_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (refs.valid && refs.ready) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (refs.valid && refs.ready) begin
			page_s1 <= refs.page;
			last_s1 <= refs.last_reference;
		end
	end

	// Lowest matching frame and lowest empty frame.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		emp     = 1'b0;
		emp_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (in_use[i] && frame_valid[i] && frame_page[i] == page_s1) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (in_use[i] && !frame_valid[i]) begin
				emp     = 1'b1;
				emp_idx = IDX_W'(i);
			end
		end
	end

	// Victim: the lowest frame in use whose rank is the greatest.
	always_comb begin
		logic is_max;
		vic_oh  = '0;
		vic_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			is_max = in_use[i];
			for (int j = 0; j < FRAMES; j++) begin
				if (j != i && in_use[j]) begin
					if (j < i) begin
						is_max = is_max && (age_rank[j] < age_rank[i]);
					end else begin
						is_max = is_max && (age_rank[j] <= age_rank[i]);
					end
				end
			end
			vic_oh[i] = is_max;
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (vic_oh[i]) begin
				vic_idx = vic_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		slot_sel = hit ? hit_idx : (emp ? emp_idx : vic_idx);
		push_entry.page        = page_s1;
		push_entry.last        = last_s1;
		push_entry.hit         = hit;
		push_entry.was_valid   = hit || !emp;
		push_entry.slot        = IDX_MAX_W'(slot_sel);
		push_entry.old_rank    = IDX_MAX_W'(age_rank[slot_sel]);
		push_entry.evict_valid = !hit && !emp;
		push_entry.evict_page  = (!hit && !emp) ? frame_page[vic_idx] : '0;
	end

endmodule

// ===== rtl/core/lpr_queue.sv =====
// Short queue of lookup outcomes between front and back end.
// Depends on lpr_pkg.
module lpr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lpr_pkg::lpr_class_t push_entry,
	input  logic                pop,
	output logic                empty,
	output lpr_pkg::lpr_class_t head
);
	import lpr_pkg::*;

	lpr_class_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/core/lpr_back.sv =====
// Back end: applies lookup outcomes to the frame state, counts faults and
// holds the result register. Depends on lpr_pkg and lpr_out_if.
module lpr_back #(
	parameter int  FRAMES = lpr_pkg::FRAMES_DEF,
	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [FRAMES-1:0]          in_use,
	input  logic                       q_empty,
	input  lpr_pkg::lpr_class_t        q_head,
	output logic                       q_pop,
	output logic [lpr_pkg::PAGE_W-1:0] frame_page [FRAMES],
	output logic [FRAMES-1:0]          frame_valid,
	output logic [IDX_W-1:0]           age_rank [FRAMES],
	lpr_out_if.source                  results
);
	import lpr_pkg::*;

	localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);

	logic [PAGE_W-1:0]  page_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;
	logic [IDX_W-1:0]   rank_q [FRAMES];
	logic [FAULT_W-1:0] faults_q;

	logic               out_vld_q;
	logic               out_hit_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_ev_vld_q;
	logic [PAGE_W-1:0]  out_ev_page_q;
	logic [FAULT_W-1:0] out_faults_q;
	logic               out_done_q;

	logic [IDX_W-1:0]   slot;
	logic [IDX_W-1:0]   old_rank;
	logic [FRAMES-1:0]  age;
	logic [FAULT_W-1:0] faults_next;

	assign frame_page  = page_q;
	assign frame_valid = valid_q;
	assign age_rank    = rank_q;

	assign q_pop = !q_empty && (!out_vld_q || results.ready);

	assign slot     = q_head.slot[IDX_W-1:0];
	assign old_rank = q_head.old_rank[IDX_W-1:0];

	// Newer frames (all, on an empty fill) age by one, saturating.
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			age[i] = in_use[i] && (i != int'(slot)) && valid_q[i]
				&& (!q_head.was_valid || rank_q[i] < old_rank)
				&& (rank_q[i] < RANK_MAX);
		end
		if (q_head.hit || faults_q == FAULT_SAT) begin
			faults_next = faults_q;
		end else begin
			faults_next = faults_q + FAULT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			faults_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (q_pop) begin
			if (q_head.last) begin
				valid_q  <= '0;
				faults_q <= '0;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= '0;
				end
			end else begin
				if (!q_head.hit) begin
					valid_q[slot] <= 1'b1;
				end
				for (int i = 0; i < FRAMES; i++) begin
					if (age[i]) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				rank_q[slot] <= '0;
				faults_q     <= faults_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !q_head.hit) begin
			page_q[slot] <= q_head.page;
		end
	end

	// Result register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (q_pop) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_hit_q     <= q_head.hit;
			out_slot_q    <= SLOT_W'(q_head.slot);
			out_ev_vld_q  <= q_head.evict_valid;
			out_ev_page_q <= q_head.evict_page;
			out_faults_q  <= faults_next;
			out_done_q    <= q_head.last;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.hit           = out_hit_q;
	assign results.slot          = out_slot_q;
	assign results.evicted_valid = out_ev_vld_q;
	assign results.evicted_page  = out_ev_page_q;
	assign results.fault_count   = out_faults_q;
	assign results.string_done   = out_done_q;

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// Top level of the LRU page replacement block: frame count register, front
// end, lookup queue and back end. Depends on lpr_pkg, lpr_in_if, lpr_out_if,
// lpr_front, lpr_queue and lpr_back.
//
// Usage:
//   refs carries one page reference per item (page, last_reference); results
//   carries one item per reference: hit, slot, evicted_valid, evicted_page,
//   fault_count and string_done. Both use valid/ready; an item moves on a
//   rising edge with valid and ready high.
//   cfg_we/cfg_wdata write frame_count (frames in use); write it only while
//   no reference is in flight. Zero acts as one, values above FRAMES as FRAMES.
// Flow:
//   A reference accepted on refs waits in the input stage, is looked up into
//   the queue and is then applied by the back end, which loads the result
//   register. The lookup in the front end reads the frame state, so it waits
//   until the back end has applied the previous reference.
// Reset:
//   arst_n empties all frames, clears ranks and the fault count, and sets
//   frame_count to 4. A reference marked last empties the frames and clears
//   ranks and the fault count again once its result is formed.
// Backpressure:
//   While results stalls, the result register holds; one lookup waits in the
//   queue and one reference in the input stage, then refs drops ready.
module lru_page_replacement #(
	parameter int FRAMES = lpr_pkg::FRAMES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lpr_in_if.sink                    refs,
	lpr_out_if.source                 results,
	input  logic                      cfg_we,
	input  logic [lpr_pkg::CFG_W-1:0] cfg_wdata
);
	import lpr_pkg::*;

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [CFG_W-1:0]  frame_count_q;
	logic [FRAMES-1:0] in_use;

	logic [PAGE_W-1:0] frame_page [FRAMES];
	logic [FRAMES-1:0] frame_valid;
	logic [IDX_W-1:0]  age_rank [FRAMES];

	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	lpr_class_t        push_entry;
	lpr_class_t        q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_we) begin
			frame_count_q <= cfg_wdata;
		end
	end

	// Frame 0 is always in use; a count above FRAMES covers every frame.
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i] = (i == 0) || (i < int'(frame_count_q));
		end
	end

	lpr_front #(.FRAMES(FRAMES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.refs       (refs),
		.in_use     (in_use),
		.frame_page (frame_page),
		.frame_valid(frame_valid),
		.age_rank   (age_rank),
		.q_empty    (q_empty),
		.q_push     (q_push),
		.push_entry (push_entry)
	);

	lpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(push_entry),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	lpr_back #(.FRAMES(FRAMES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_use     (in_use),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.frame_page (frame_page),
		.frame_valid(frame_valid),
		.age_rank   (age_rank),
		.results    (results)
	);

	// A lookup must never run against state with an update still pending.
	a_push_on_drained: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_empty)
		else $error("lookup pushed while queue not drained");

	// An eviction is only chosen when every frame in use is occupied.
	a_evict_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && push_entry.evict_valid) |-> ((frame_valid & in_use) == in_use))
		else $error("eviction chosen with an empty frame available");

	// The end of a string leaves every frame empty.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.last) |=> (frame_valid == '0))
		else $error("frames not emptied after last reference");

endmodule

// ===== verif/lru_page_replacement_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement: drives page references,
// predicts each lookup result and compares it with the block's output.
// Depends on lpr_pkg, lpr_in_if, lpr_out_if and the lru_page_replacement RTL.
module lru_page_replacement_tb;
	import lpr_pkg::*;

	localparam int FRAMES     = FRAMES_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_SHOWN  = 10;
	localparam int CFG_SETTLE = 4;

	// One expected lookup result, field for field as the result channel carries it.
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [FAULT_W-1:0] fault_count;
		logic               string_done;
	} lookup_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lpr_in_if  refs_if ();
	lpr_out_if res_if ();

	lru_page_replacement #(
		.FRAMES(FRAMES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.refs     (refs_if),
		.results  (res_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Predicted frame state, kept in step with every accepted reference.
	logic [PAGE_W-1:0]  resident_page [FRAMES];
	logic               resident_valid[FRAMES];
	logic [SLOT_W-1:0]  recency_rank  [FRAMES];
	logic [FAULT_W-1:0] fault_total;
	logic [CFG_W-1:0]   frames_cfg;

	lookup_result_t pending_lookups[$];

	int  mismatch_count;
	int  idle_cycles;
	bit  src_idle_on;
	bit  sink_stall_on;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int frames_in_use();
		if (frames_cfg == '0)
			return 1;
		if (int'(frames_cfg) > FRAMES)
			return FRAMES;
		return int'(frames_cfg);
	endfunction

	function automatic void empty_all_frames();
		for (int i = 0; i < FRAMES; i++) begin
			resident_valid[i] = 1'b0;
			recency_rank[i]   = '0;
		end
		fault_total = '0;
	endfunction

	// Make frame s the most recent; frames younger than its old rank age by one.
	function automatic void refresh_recency(int s, int used, int old_rank);
		for (int i = 0; i < used; i++) begin
			if (i != s && resident_valid[i] && int'(recency_rank[i]) < old_rank &&
				int'(recency_rank[i]) < FRAMES - 1)
				recency_rank[i] = recency_rank[i] + 1'b1;
		end
		recency_rank[s] = '0;
	endfunction

	function automatic lookup_result_t predict_lookup(logic [PAGE_W-1:0] pg, logic last);
		lookup_result_t r;
		int used;
		int s;
		int best;
		int old_rank;
		bit found;
		bit got_empty;
		r         = '0;
		used      = frames_in_use();
		s         = 0;
		found     = 1'b0;
		got_empty = 1'b0;
		// Lowest matching frame wins when a page sits in two frames.
		for (int i = 0; i < used; i++) begin
			if (!found && resident_valid[i] && resident_page[i] == pg) begin
				found = 1'b1;
				s     = i;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			refresh_recency(s, used, int'(recency_rank[s]));
		end else begin
			if (fault_total != FAULT_SAT)
				fault_total = fault_total + 1'b1;
			for (int i = 0; i < used; i++) begin
				if (!got_empty && !resident_valid[i]) begin
					got_empty = 1'b1;
					s         = i;
				end
			end
			if (got_empty) begin
				old_rank = FRAMES;
			end else begin
				// Victim: oldest rank, lowest frame on a tie.
				best = 0;
				s    = 0;
				for (int i = 0; i < used; i++) begin
					if (i == 0 || int'(recency_rank[i]) > best) begin
						best = int'(recency_rank[i]);
						s    = i;
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page  = resident_page[s];
				old_rank        = int'(recency_rank[s]);
			end
			refresh_recency(s, used, old_rank);
			resident_page[s]  = pg;
			resident_valid[s] = 1'b1;
		end
		r.slot        = SLOT_W'(s);
		r.fault_count = fault_total;
		r.string_done = last;
		if (last)
			empty_all_frames();
		return r;
	endfunction

	// Offer one reference and hold it until accepted; predict on acceptance.
	task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic last);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			refs_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		refs_if.valid          <= 1'b1;
		refs_if.page           <= pg;
		refs_if.last_reference <= last;
		do
			@(posedge clk);
		while (!refs_if.ready);
		pending_lookups.push_back(predict_lookup(pg, last));
		@(negedge clk);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic drain_results();
		refs_if.valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_frame_count(input logic [CFG_W-1:0] v);
		drain_results();
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we     <= 1'b0;
		frames_cfg  = v;
	endtask

	// Fill, hit, evict the oldest frame, then end the string with the default count.
	task automatic test_basic_lookup();
		send_ref(16'h0000, 1'b0);
		send_ref(16'hFFFF, 1'b0);
		send_ref(16'h0000, 1'b0);
		send_ref(16'h0001, 1'b0);
		send_ref(16'h0002, 1'b0);
		send_ref(16'h0003, 1'b0);
		send_ref(16'h0000, 1'b1);
	endtask

	// Smallest and out-of-range counts: one frame, zero acting as one, 31 as FRAMES.
	task automatic test_count_limits();
		write_frame_count(CFG_W'(1));
		send_ref(16'h0005, 1'b0);
		send_ref(16'h0005, 1'b0);
		send_ref(16'h0006, 1'b0);
		send_ref(16'h0007, 1'b1);
		write_frame_count(CFG_W'(0));
		send_ref(16'h0008, 1'b0);
		send_ref(16'h0009, 1'b1);
		write_frame_count(CFG_W'(31));
		send_ref(16'h1234, 1'b0);
		send_ref(16'h1234, 1'b0);
		send_ref(16'hFFFF, 1'b1);
	endtask

	// Shrink the count mid-string so a page lands twice, then grow it back so the
	// hidden frames become visible again.
	task automatic test_hidden_frames();
		write_frame_count(CFG_W'(4));
		send_ref(16'h00A0, 1'b0);
		send_ref(16'h00B0, 1'b0);
		send_ref(16'h00C0, 1'b0);
		send_ref(16'h00D0, 1'b0);
		write_frame_count(CFG_W'(2));
		send_ref(16'h00C0, 1'b0);
		write_frame_count(CFG_W'(4));
		send_ref(16'h00C0, 1'b0);
		send_ref(16'h00D0, 1'b0);
		send_ref(16'h00E0, 1'b1);
	endtask

	// Reference strings drawn from a small working set, with some noise pages and
	// stray string ends. A phase may stop mid-string, so the next count applies
	// to frames that are still filled.
	task automatic run_random_phase(input logic [CFG_W-1:0] count_val, input int n_items,
		input bit with_idle);
		logic [PAGE_W-1:0] pool[24];
		logic [PAGE_W-1:0] pg;
		logic              lst;
		int                sent;
		int                pool_n;
		int                str_len;
		int                mode;
		write_frame_count(count_val);
		src_idle_on   = with_idle;
		sink_stall_on = with_idle;
		sent = 0;
		while (sent < n_items) begin
			pool_n = frames_in_use() + $urandom_range(0, 4);
			mode   = $urandom_range(0, 3);
			for (int i = 0; i < pool_n; i++) begin
				case (mode)
					0: begin
						pool[i] = PAGE_W'($urandom_range(0, 31));
					end
					1: begin
						pool[i] = 16'hFFFF - PAGE_W'($urandom_range(0, 31));
					end
					default: begin
						pool[i] = PAGE_W'($urandom);
					end
				endcase
			end
			str_len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
			for (int k = 0; k < str_len && sent < n_items; k++) begin
				if ($urandom_range(0, 9) == 0)
					pg = PAGE_W'($urandom);
				else
					pg = pool[$urandom_range(0, pool_n - 1)];
				lst = (k == str_len - 1) || ($urandom_range(0, 63) == 0);
				send_ref(pg, lst);
				sent++;
			end
			if (with_idle && $urandom_range(0, 7) == 0)
				drain_results();
		end
	endtask

	task automatic test_random_strings();
		run_random_phase(CFG_W'(1), 100, 1'b1);
		run_random_phase(CFG_W'(16), 120, 1'b1);
		run_random_phase(CFG_W'(0), 60, 1'b1);
		run_random_phase(CFG_W'(31), 120, 1'b1);
		run_random_phase(CFG_W'(2), 90, 1'b1);
		run_random_phase(CFG_W'(3), 90, 1'b1);
		run_random_phase(CFG_W'(8), 100, 1'b1);
		run_random_phase(CFG_W'(17), 100, 1'b1);
		run_random_phase(CFG_W'($urandom_range(1, 15)), 100, 1'b1);
		run_random_phase(CFG_W'($urandom_range(0, 31)), 100, 1'b1);
		// Closing stretch: both sides run flat out.
		run_random_phase(CFG_W'(16), 120, 1'b0);
	endtask

	// Result sink: ready drops in short random bursts while stalls are enabled.
	initial begin : sink_ready_gen
		int burst;
		burst = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_stall_on && burst == 0 && $urandom_range(0, 5) == 0)
				burst = $urandom_range(1, 4);
			if (burst != 0) begin
				res_if.ready <= 1'b0;
				burst--;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin : check_results
		lookup_result_t want;
		lookup_result_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.hit           = res_if.hit;
			got.slot          = res_if.slot;
			got.evicted_valid = res_if.evicted_valid;
			got.evicted_page  = res_if.evicted_page;
			got.fault_count   = res_if.fault_count;
			got.string_done   = res_if.string_done;
			if (pending_lookups.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN)
					$display("%0t: result with no reference pending: hit=%0b slot=%0d",
						$realtime, got.hit, got.slot);
			end else begin
				want = pending_lookups.pop_front();
				if (got.hit !== want.hit || got.slot !== want.slot ||
					got.evicted_valid !== want.evicted_valid ||
					got.evicted_page !== want.evicted_page ||
					got.fault_count !== want.fault_count ||
					got.string_done !== want.string_done) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN) begin
						$display("%0t: lookup mismatch", $realtime);
						$display("  expected hit=%0b slot=%0d evicted=%0b/%h faults=%0d done=%0b",
							want.hit, want.slot, want.evicted_valid, want.evicted_page,
							want.fault_count, want.string_done);
						$display("  actual   hit=%0b slot=%0d evicted=%0b/%h faults=%0d done=%0b",
							got.hit, got.slot, got.evicted_valid, got.evicted_page,
							got.fault_count, got.string_done);
					end
				end
			end
		end
	end

	// Watchdog: end the run if no item moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (refs_if.valid && refs_if.ready) || (res_if.valid && res_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		refs_if.valid          = 1'b0;
		refs_if.page           = '0;
		refs_if.last_reference = 1'b0;
		mismatch_count         = 0;
		idle_cycles            = 0;
		src_idle_on            = 1'b1;
		sink_stall_on          = 1'b1;
		frames_cfg             = FRAME_COUNT_RST;
		for (int i = 0; i < FRAMES; i++)
			resident_page[i] = '0;
		empty_all_frames();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_lookup();
		test_count_limits();
		test_hidden_frames();
		test_random_strings();

		drain_results();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && pending_lookups.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== lru_page_replacement.f =====
rtl/core/lpr_pkg.sv
rtl/core/lpr_in_if.sv
rtl/core/lpr_out_if.sv
rtl/core/lpr_front.sv
rtl/core/lpr_queue.sv
rtl/core/lpr_back.sv
rtl/core/lru_page_replacement.sv
verif/lru_page_replacement_tb.sv
